>>> hdl/tpmf_pkg.sv
package tpmf_pkg;

	// Widths of the raw and scaled sample and of the reported position.
	localparam int unsigned RAW_W    = 10;
	localparam int unsigned SCALED_W = 7;
	localparam int unsigned POS_W    = 8;

	// Scaling drops the low bits of the raw reading.
	localparam int unsigned SCALE_SHIFT = 3;

	// Position is reported as full scale minus the median.
	localparam logic [POS_W-1:0] FULL_SCALE = 8'd128;

	// Threshold value after reset.
	localparam logic [SCALED_W-1:0] THRESHOLD_RESET = 7'd10;

	// One classified sample, as passed from the front end to the sorter.
	typedef struct packed {
		logic [SCALED_W-1:0] value;
		logic                is_y;
		logic                last;
	} sample_item_t;

	// Status of the queue between front and back.
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

>>> hdl/tpmf_intf.sv
// Raw ADC sample stream.
interface tpmf_sample_if;
	logic                          valid;
	logic                          ready;
	logic [tpmf_pkg::RAW_W-1:0]    sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

// Filtered touch point stream.
interface tpmf_point_if;
	logic                          valid;
	logic                          ready;
	logic [tpmf_pkg::POS_W-1:0]    x_position;
	logic [tpmf_pkg::POS_W-1:0]    y_position;
	logic                          pressed;

	modport source (output valid, output x_position, output y_position, output pressed,
		input ready);
	modport sink   (input valid, input x_position, input y_position, input pressed,
		output ready);
endinterface

// Threshold register write channel.
interface tpmf_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [tpmf_pkg::SCALED_W-1:0]  pressure_threshold;

	modport source (output valid, output pressure_threshold, input ready);
	modport sink   (input valid, input pressure_threshold, output ready);
endinterface

>>> hdl/tpmf_front.sv
module tpmf_front #(
	parameter int unsigned N = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic [tpmf_pkg::RAW_W-1:0] in_sample,
	output logic                   in_ready,
	input  tpmf_pkg::queue_status_t q_status,
	output logic                   push,
	output tpmf_pkg::sample_item_t push_item
);

	localparam int unsigned CNT_W = $clog2(2 * N);

	logic [CNT_W-1:0] cnt_q;
	logic             last_of_point;

	// A sample is taken whenever the queue has room.
	assign in_ready = !q_status.full;
	assign push     = in_valid && in_ready;

	// Scale the sample and tag it with its axis and end-of-axis mark.
	assign last_of_point   = (cnt_q == CNT_W'(2 * N - 1));
	assign push_item.value = in_sample[tpmf_pkg::RAW_W-1:tpmf_pkg::SCALE_SHIFT];
	assign push_item.is_y  = (cnt_q >= CNT_W'(N));
	assign push_item.last  = (cnt_q == CNT_W'(N - 1)) || last_of_point;

	// Position of the sample within the current point.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (push) begin
			if (last_of_point) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

endmodule

>>> hdl/tpmf_queue.sv
module tpmf_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  tpmf_pkg::sample_item_t  push_item,
	input  logic                    pop,
	output tpmf_pkg::sample_item_t  pop_item,
	output tpmf_pkg::queue_status_t status
);

	tpmf_pkg::sample_item_t entry_q [2];
	logic                   wr_ptr_q;
	logic                   rd_ptr_q;
	logic [1:0]             count_q;

	assign status.full  = (count_q == 2'd2);
	assign status.empty = (count_q == 2'd0);
	assign pop_item     = entry_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

>>> hdl/tpmf_sorter.sv
module tpmf_sorter #(
	parameter int unsigned N = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tpmf_pkg::queue_status_t           q_status,
	input  tpmf_pkg::sample_item_t            pop_item,
	output logic                              pop,
	input  logic [tpmf_pkg::SCALED_W-1:0]     threshold,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [tpmf_pkg::POS_W-1:0]        x_position,
	output logic [tpmf_pkg::POS_W-1:0]        y_position,
	output logic                              pressed
);

	localparam int unsigned FILL_W = $clog2(N);
	localparam int unsigned MED    = (N - 1) / 2;

	logic [tpmf_pkg::SCALED_W-1:0] cell_q    [N];
	logic [tpmf_pkg::SCALED_W-1:0] cell_next [N];
	logic [N-1:0]                  le;
	logic [FILL_W-1:0]             fill_q;
	logic [tpmf_pkg::SCALED_W-1:0] held_x_q;
	logic [tpmf_pkg::SCALED_W-1:0] median;
	logic                          emit;
	logic                          out_valid_q;
	logic [tpmf_pkg::POS_W-1:0]    x_pos_q;
	logic [tpmf_pkg::POS_W-1:0]    y_pos_q;
	logic                          pressed_q;

	// A Y end-of-axis item needs a free output register; others proceed whenever queued.
	assign pop  = !q_status.empty &&
		(!(pop_item.last && pop_item.is_y) || !out_valid_q || out_ready);
	assign emit = pop && pop_item.last && pop_item.is_y;

	// Insertion cells: occupied cells not above the new value keep their place,
	// the first larger one takes the new value and the rest shift up by one.
	always_comb begin
		for (int i = 0; i < N; i++) begin
			le[i] = (FILL_W'(i) < fill_q) && (cell_q[i] <= pop_item.value);
		end
		for (int i = 0; i < N; i++) begin
			if (le[i]) begin
				cell_next[i] = cell_q[i];
			end else if (i == 0) begin
				cell_next[i] = pop_item.value;
			end else if (le[i-1]) begin
				cell_next[i] = pop_item.value;
			end else begin
				cell_next[i] = cell_q[i-1];
			end
		end
	end

	// The lower median sits at a fixed cell once the axis is complete.
	assign median = cell_next[MED];

	always_ff @(posedge clk) begin
		if (pop) begin
			for (int i = 0; i < N; i++) begin
				cell_q[i] <= cell_next[i];
			end
		end
	end

	// Number of cells filled in the current axis.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (pop) begin
			if (pop_item.last) begin
				fill_q <= '0;
			end else begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	// X median is held until the Y axis is done.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_x_q <= '0;
		end else if (pop && pop_item.last && !pop_item.is_y) begin
			held_x_q <= median;
		end
	end

	// Output register holding one finished point until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			x_pos_q   <= tpmf_pkg::FULL_SCALE - {1'b0, held_x_q};
			y_pos_q   <= tpmf_pkg::FULL_SCALE - {1'b0, median};
			pressed_q <= (held_x_q > threshold) && (median > threshold);
		end
	end

	assign out_valid  = out_valid_q;
	assign x_position = x_pos_q;
	assign y_position = y_pos_q;
	assign pressed    = pressed_q;

endmodule

>>> hdl/touch_point_median_filter_core.sv
// Median filter for a resistive touch panel. Raw 10-bit ADC samples arrive on
// the samples channel: the first N of each point are X readings, the next N are
// Y readings. Each reading is scaled to 7 bits and inserted into a sorted row
// of N cells; after the last reading of an axis the lower median (sorted index
// (N-1)/2) is taken. After the 2N-th reading one point is sent on the points
// channel with 128 minus each median and a pressed flag, set when both medians
// exceed the pressure threshold written on the cfg channel (reset value 10).
// A sample is taken in every cycle while the two-entry queue between intake
// and sorter has room, and the sorter retires one sample a cycle; it only
// waits when a finished point is still held in the output register and the
// next point completes, so throughput is one sample per cycle, with a finished
// point presented in the cycle after its last sample is sorted.
module touch_point_median_filter_core #(
	parameter int unsigned N = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	tpmf_sample_if.sink         samples,
	tpmf_point_if.source        points,
	tpmf_cfg_if.sink            cfg
);

	logic                          push;
	logic                          pop;
	tpmf_pkg::sample_item_t        push_item;
	tpmf_pkg::sample_item_t        pop_item;
	tpmf_pkg::queue_status_t       q_status;
	logic [tpmf_pkg::SCALED_W-1:0] threshold_q;

	// Threshold register; writes are always taken.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= tpmf_pkg::THRESHOLD_RESET;
		end else if (cfg.valid) begin
			threshold_q <= cfg.pressure_threshold;
		end
	end

	// Intake and classification.
	tpmf_front #(.N(N)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_sample (samples.sample),
		.in_ready  (samples.ready),
		.q_status  (q_status),
		.push      (push),
		.push_item (push_item)
	);

	// Decoupling queue.
	tpmf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.status    (q_status)
	);

	// Sorting cells, medians and output register.
	tpmf_sorter #(.N(N)) u_sorter (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_status   (q_status),
		.pop_item   (pop_item),
		.pop        (pop),
		.threshold  (threshold_q),
		.out_valid  (points.valid),
		.out_ready  (points.ready),
		.x_position (points.x_position),
		.y_position (points.y_position),
		.pressed    (points.pressed)
	);

endmodule

>>> bench/touch_point_median_filter_core_tb.sv
module touch_point_median_filter_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned AXIS_SAMPLES  = 8;
	localparam int unsigned MEDIAN_RANK   = (AXIS_SAMPLES - 1) >> 1;
	localparam int unsigned POINT_SAMPLES = 2 * AXIS_SAMPLES;
	localparam int unsigned PHASES        = 12;
	localparam int unsigned SETTLE_CYCLES = 16;
	localparam int unsigned HOLD_CYCLES   = 300;
	localparam int unsigned REPORT_LIMIT  = 50;
	localparam longint unsigned CYCLE_LIMIT = 1000000;

	// Entries of the stimulus feed: a sample, a threshold write, a wait for
	// the block to go idle, a long output hold, or a change of input pacing.
	typedef enum logic [2:0] {
		FEED_SAMPLE,
		FEED_THRESHOLD,
		FEED_SETTLE,
		FEED_HOLD,
		FEED_PACE
	} feed_kind_t;

	typedef struct {
		feed_kind_t  kind;
		int unsigned value;
	} feed_t;

	// How the eight samples of one axis are drawn.
	typedef enum int {
		SHAPE_UNIFORM,
		SHAPE_CLUSTER,
		SHAPE_TIES,
		SHAPE_THRESHOLD,
		SHAPE_EXTREME,
		SHAPE_RAMP
	} shape_t;

	typedef struct packed {
		logic [tpmf_pkg::POS_W-1:0] x_position;
		logic [tpmf_pkg::POS_W-1:0] y_position;
		logic                       pressed;
	} point_t;

	logic clk;
	logic arst_n;

	tpmf_sample_if sample_ch ();
	tpmf_point_if  point_ch ();
	tpmf_cfg_if    cfg_ch ();

	touch_point_median_filter_core #(
		.N(AXIS_SAMPLES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.samples(sample_ch),
		.points(point_ch),
		.cfg(cfg_ch)
	);

	// Filter state as the testbench tracks it.
	logic [tpmf_pkg::SCALED_W-1:0] axis_store [AXIS_SAMPLES];
	int unsigned                   point_fill;
	logic [tpmf_pkg::SCALED_W-1:0] held_x;
	logic [tpmf_pkg::SCALED_W-1:0] threshold_now;

	point_t expected_points [$];
	feed_t  pending [$];

	int unsigned errors;
	int unsigned samples_taken;
	int unsigned points_seen;
	int unsigned pressed_seen;
	int unsigned writes_done;
	longint unsigned cycle_count;

	// Handshake between the sample driver and the point sink for long holds.
	int          hold_seq;
	int          hold_seen;
	int unsigned hold_len;

	bit          paced = 1'b1;
	int unsigned gap_left;
	int unsigned settle_count;
	int unsigned stall_left;
	int unsigned calm_left;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Lower median of the axis store: the element whose sorted position range
	// covers the median rank.
	function automatic logic [tpmf_pkg::SCALED_W-1:0] axis_median();
		int unsigned below;
		int unsigned not_above;
		axis_median = '0;
		for (int i = 0; i < AXIS_SAMPLES; i++) begin
			below = 0;
			not_above = 0;
			for (int j = 0; j < AXIS_SAMPLES; j++) begin
				if (axis_store[j] < axis_store[i])
					below++;
				if (axis_store[j] <= axis_store[i])
					not_above++;
			end
			if (below <= MEDIAN_RANK && MEDIAN_RANK < not_above)
				axis_median = axis_store[i];
		end
	endfunction

	// Take one raw sample into the point being built; queue the point when
	// its last Y sample arrives.
	function automatic void absorb_sample(input logic [tpmf_pkg::RAW_W-1:0] raw);
		logic [tpmf_pkg::SCALED_W-1:0] y_med;
		point_t                        p;
		axis_store[point_fill % AXIS_SAMPLES] =
			raw[tpmf_pkg::RAW_W-1:tpmf_pkg::SCALE_SHIFT];
		point_fill++;
		if (point_fill == AXIS_SAMPLES) begin
			held_x = axis_median();
		end else if (point_fill == POINT_SAMPLES) begin
			y_med = axis_median();
			point_fill = 0;
			p.x_position = tpmf_pkg::FULL_SCALE - tpmf_pkg::POS_W'(held_x);
			p.y_position = tpmf_pkg::FULL_SCALE - tpmf_pkg::POS_W'(y_med);
			p.pressed = (held_x > threshold_now) && (y_med > threshold_now);
			expected_points.push_back(p);
		end
	endfunction

	// Idle stretch length: mostly none or short, now and then long.
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// One raw sample of the given shape; the low bits are always random.
	function automatic logic [tpmf_pkg::RAW_W-1:0] shaped_raw(input shape_t shape,
		input int center, input int thr, input int step);
		int s;
		if (shape == SHAPE_UNIFORM)
			return tpmf_pkg::RAW_W'($urandom_range(0, (1 << tpmf_pkg::RAW_W) - 1));
		case (shape)
			SHAPE_CLUSTER:   s = center + int'($urandom_range(0, 4)) - 2;
			SHAPE_TIES:      s = center;
			SHAPE_THRESHOLD: s = thr + int'($urandom_range(0, 2)) - 1;
			SHAPE_EXTREME:   s = ($urandom_range(0, 1) != 0) ? 127 : 0;
			default:         s = center + step * 3 - 10;
		endcase
		if (s < 0)
			s = 0;
		if (s > 127)
			s = 127;
		return {s[tpmf_pkg::SCALED_W-1:0], tpmf_pkg::SCALE_SHIFT'($urandom_range(0, 7))};
	endfunction

	function automatic shape_t pick_shape();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 25)
			return SHAPE_UNIFORM;
		if (r < 45)
			return SHAPE_CLUSTER;
		if (r < 55)
			return SHAPE_TIES;
		if (r < 75)
			return SHAPE_THRESHOLD;
		if (r < 85)
			return SHAPE_EXTREME;
		return SHAPE_RAMP;
	endfunction

	// Sample and threshold driver, fed from the pending queue.
	always @(posedge clk) begin : feed_driver
		logic offer_sample;
		logic offer_write;
		offer_sample = sample_ch.valid;
		offer_write = cfg_ch.valid;
		if (arst_n) begin
			if (sample_ch.valid && sample_ch.ready) begin
				absorb_sample(sample_ch.sample);
				samples_taken++;
				offer_sample = 1'b0;
				gap_left = paced ? idle_len() : 0;
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				threshold_now = cfg_ch.pressure_threshold;
				writes_done++;
				offer_write = 1'b0;
			end
			if (!offer_sample && !offer_write) begin
				if (gap_left != 0) begin
					gap_left--;
				end else if (pending.size() != 0) begin
					case (pending[0].kind)
						FEED_SAMPLE: begin
							offer_sample = 1'b1;
							sample_ch.sample <= tpmf_pkg::RAW_W'(pending[0].value);
							void'(pending.pop_front());
						end
						FEED_THRESHOLD: begin
							offer_write = 1'b1;
							cfg_ch.pressure_threshold <=
								tpmf_pkg::SCALED_W'(pending[0].value);
							void'(pending.pop_front());
						end
						FEED_SETTLE: begin
							// Wait for every point, then let the pipeline empty.
							if (expected_points.size() == 0) begin
								settle_count++;
								if (settle_count >= SETTLE_CYCLES) begin
									settle_count = 0;
									void'(pending.pop_front());
								end
							end else begin
								settle_count = 0;
							end
						end
						FEED_HOLD: begin
							hold_len <= pending[0].value;
							hold_seq <= hold_seq + 1;
							void'(pending.pop_front());
						end
						default: begin
							paced = (pending[0].value != 0);
							void'(pending.pop_front());
						end
					endcase
				end
			end
			sample_ch.valid <= offer_sample;
			cfg_ch.valid <= offer_write;
		end
	end

	// Point sink ready: random stalls, calm stretches, and long holds on request.
	always @(posedge clk) begin : point_sink
		if (arst_n) begin
			if (hold_seq != hold_seen) begin
				hold_seen = hold_seq;
				stall_left = hold_len;
			end
			if (stall_left != 0) begin
				stall_left--;
				point_ch.ready <= 1'b0;
			end else if (calm_left != 0) begin
				calm_left--;
				point_ch.ready <= 1'b1;
			end else begin
				if ($urandom_range(0, 39) == 0)
					calm_left = $urandom_range(30, 120);
				else if ($urandom_range(0, 3) == 0)
					stall_left = idle_len();
				point_ch.ready <= (stall_left == 0);
			end
		end
	end

	// Compare every point transfer against the oldest expected point.
	always @(posedge clk) begin : point_check
		point_t want;
		if (arst_n && point_ch.valid && point_ch.ready) begin
			if (expected_points.size() == 0) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("%0t: expected no point, got x=%0d y=%0d pressed=%0d", $time,
						point_ch.x_position, point_ch.y_position, point_ch.pressed);
			end else begin
				want = expected_points.pop_front();
				points_seen++;
				if (want.pressed)
					pressed_seen++;
				if (point_ch.x_position !== want.x_position) begin
					errors++;
					if (errors <= REPORT_LIMIT)
						$display("%0t: x_position expected %0d, got %0d", $time,
							want.x_position, point_ch.x_position);
				end
				if (point_ch.y_position !== want.y_position) begin
					errors++;
					if (errors <= REPORT_LIMIT)
						$display("%0t: y_position expected %0d, got %0d", $time,
							want.y_position, point_ch.y_position);
				end
				if (point_ch.pressed !== want.pressed) begin
					errors++;
					if (errors <= REPORT_LIMIT)
						$display("%0t: pressed expected %0d, got %0d", $time,
							want.pressed, point_ch.pressed);
				end
			end
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d points outstanding", $time,
				cycle_count, expected_points.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int unsigned thr;
		int unsigned phase_len;
		int unsigned step_idx;
		shape_t      shape;
		int          center;

		arst_n = 1'b0;
		sample_ch.valid = 1'b0;
		sample_ch.sample = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.pressure_threshold = '0;
		point_ch.ready = 1'b0;
		threshold_now = tpmf_pkg::THRESHOLD_RESET;
		held_x = '0;
		point_fill = 0;
		for (int i = 0; i < AXIS_SAMPLES; i++)
			axis_store[i] = '0;

		// Directed points at the reset threshold. First: X mostly full scale
		// with zeros mixed in, Y tied exactly at the threshold (not pressed).
		// Second: distinct descending X, Y tied one above the threshold.
		thr = tpmf_pkg::THRESHOLD_RESET;
		for (int i = 0; i < AXIS_SAMPLES; i++)
			pending.push_back('{FEED_SAMPLE, (i % 2 == 0 || i == AXIS_SAMPLES - 1) ? 1023 : 0});
		for (int i = 0; i < AXIS_SAMPLES; i++)
			pending.push_back('{FEED_SAMPLE, 80 + i});
		for (int i = 0; i < AXIS_SAMPLES; i++)
			pending.push_back('{FEED_SAMPLE, 1023 - 100 * i});
		for (int i = 0; i < AXIS_SAMPLES; i++)
			pending.push_back('{FEED_SAMPLE, 88 + i});
		step_idx = 2 * POINT_SAMPLES;

		// Random phases, each under its own threshold. Phases may end in the
		// middle of a point, so a write can land between X and Y collection.
		for (int ph = 0; ph < PHASES; ph++) begin
			pending.push_back('{FEED_SETTLE, 0});
			case (ph)
				0:       thr = 0;
				1:       thr = 127;
				2:       thr = 1;
				3:       thr = 126;
				default: thr = $urandom_range(0, 127);
			endcase
			pending.push_back('{FEED_THRESHOLD, thr});
			if (ph == 4 || ph == 9) begin
				pending.push_back('{FEED_PACE, 0});
				pending.push_back('{FEED_HOLD, HOLD_CYCLES});
			end else begin
				pending.push_back('{FEED_PACE, ($urandom_range(0, 9) < 7) ? 1 : 0});
			end
			phase_len = $urandom_range(120, 150);
			repeat (phase_len) begin
				if (step_idx % AXIS_SAMPLES == 0) begin
					shape = pick_shape();
					center = $urandom_range(0, 127);
				end
				pending.push_back('{FEED_SAMPLE, shaped_raw(shape, center, thr,
					step_idx % AXIS_SAMPLES)});
				step_idx++;
			end
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending.size() != 0 || sample_ch.valid || cfg_ch.valid
			|| expected_points.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Run covered %0d samples and %0d points (%0d pressed)",
			samples_taken, points_seen, pressed_seen);
		$display("across %0d threshold writes, including 0 and 127, long output holds and drains.",
			writes_done);
		if (errors == 0 && expected_points.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
